// File: design/hsarh_pkg.sv
`default_nettype none

package hsarh_pkg;

  // item field widths
  localparam int ACT_W   = 2;
  localparam int ROW_W   = 10;
  localparam int PIX_W   = 8;
  localparam int SEL_W   = 10;
  localparam int IDX_W   = 10;
  localparam int CNT_W   = 20;

  // register widths
  localparam int COEF_W  = 16;
  localparam int OFFS_W  = 25;
  localparam int STEP_W  = 20;
  localparam int THR_W   = 8;

  // apb
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;
  localparam int REGIX_W = PADDR_W - 2;

  // rho arithmetic: coordinate * coefficient, sum of two plus offset, times reciprocal
  localparam int PROD_W   = ROW_W + 1 + COEF_W;
  localparam int SUM_W    = PROD_W + 1;
  localparam int SCALED_W = SUM_W + STEP_W + 1;
  localparam int FRAC_W   = 30;
  localparam int BINW_W   = SCALED_W - 1 - FRAC_W;

  localparam logic signed [SCALED_W-1:0] ROUND_HALF = SCALED_W'(1) << (FRAC_W - 1);

  // action codes
  localparam logic [ACT_W-1:0] ACT_VOTE       = 2'd0;
  localparam logic [ACT_W-1:0] ACT_READ       = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ_CLEAR = 2'd2;

  // result kinds
  localparam logic KIND_VOTE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // register indexes
  localparam logic [REGIX_W-1:0] REG_COS_COEF      = 3'd0;
  localparam logic [REGIX_W-1:0] REG_SIN_COEF      = 3'd1;
  localparam logic [REGIX_W-1:0] REG_RHO_OFFSET    = 3'd2;
  localparam logic [REGIX_W-1:0] REG_INV_RHO_STEP  = 3'd3;
  localparam logic [REGIX_W-1:0] REG_VOTE_THRESHOLD = 3'd4;

  typedef struct packed {
    logic signed [COEF_W-1:0] cos_coef;
    logic signed [COEF_W-1:0] sin_coef;
    logic [OFFS_W-1:0]        rho_offset;
    logic [STEP_W-1:0]        inv_rho_step;
    logic [THR_W-1:0]         vote_threshold;
  } cfg_t;

  typedef struct packed {
    logic             kind;
    logic [IDX_W-1:0] bin_index;
    logic [CNT_W-1:0] bin_count;
    logic             voted;
    logic             out_of_range;
    logic             saturated;
  } res_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_SCALE,
    ST_ADDR,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// File: design/hsarh_req_if.sv
`default_nettype none

interface hsarh_req_if;
  logic                          valid;
  logic                          ready;
  logic [hsarh_pkg::ACT_W-1:0]   action;
  logic [hsarh_pkg::ROW_W-1:0]   row;
  logic [hsarh_pkg::ROW_W-1:0]   col;
  logic [hsarh_pkg::PIX_W-1:0]   pixel_value;
  logic [hsarh_pkg::SEL_W-1:0]   bin_select;

  modport source (output valid, action, row, col, pixel_value, bin_select, input ready);
  modport sink   (input valid, action, row, col, pixel_value, bin_select, output ready);
endinterface

`default_nettype wire

// File: design/hsarh_rsp_if.sv
`default_nettype none

interface hsarh_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [hsarh_pkg::IDX_W-1:0]   bin_index;
  logic [hsarh_pkg::CNT_W-1:0]   bin_count;
  logic                          voted;
  logic                          out_of_range;
  logic                          saturated;

  modport source (output valid, kind, bin_index, bin_count, voted, out_of_range, saturated,
                  input ready);
  modport sink   (input valid, kind, bin_index, bin_count, voted, out_of_range, saturated,
                  output ready);
endinterface

`default_nettype wire

// File: design/hsarh_regs.sv
`default_nettype none

module hsarh_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [hsarh_pkg::PADDR_W-1:0]   paddr,
  input  logic [hsarh_pkg::PDATA_W-1:0]   pwdata,
  output logic [hsarh_pkg::PDATA_W-1:0]   prdata,
  output logic                            pready,
  output hsarh_pkg::cfg_t                 cfg
);

  localparam int DW = hsarh_pkg::PDATA_W;

  hsarh_pkg::cfg_t               cfg_q;
  logic [hsarh_pkg::REGIX_W-1:0] reg_idx;
  logic                          wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[hsarh_pkg::PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg     = cfg_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.cos_coef       <= 16'sd0;
      cfg_q.sin_coef       <= 16'sd16384;
      cfg_q.rho_offset     <= '0;
      cfg_q.inv_rho_step   <= 20'd65536;
      cfg_q.vote_threshold <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        hsarh_pkg::REG_COS_COEF:       cfg_q.cos_coef <= $signed(pwdata[hsarh_pkg::COEF_W-1:0]);
        hsarh_pkg::REG_SIN_COEF:       cfg_q.sin_coef <= $signed(pwdata[hsarh_pkg::COEF_W-1:0]);
        hsarh_pkg::REG_RHO_OFFSET:     cfg_q.rho_offset <= pwdata[hsarh_pkg::OFFS_W-1:0];
        hsarh_pkg::REG_INV_RHO_STEP:   cfg_q.inv_rho_step <= pwdata[hsarh_pkg::STEP_W-1:0];
        hsarh_pkg::REG_VOTE_THRESHOLD: cfg_q.vote_threshold <= pwdata[hsarh_pkg::THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // readback, zero extended bit patterns
  always_comb begin
    case (reg_idx)
      hsarh_pkg::REG_COS_COEF:       prdata = DW'(unsigned'(cfg_q.cos_coef));
      hsarh_pkg::REG_SIN_COEF:       prdata = DW'(unsigned'(cfg_q.sin_coef));
      hsarh_pkg::REG_RHO_OFFSET:     prdata = DW'(cfg_q.rho_offset);
      hsarh_pkg::REG_INV_RHO_STEP:   prdata = DW'(cfg_q.inv_rho_step);
      hsarh_pkg::REG_VOTE_THRESHOLD: prdata = DW'(cfg_q.vote_threshold);
      default:                       prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: design/hough_single_angle_rho_histogram.sv
// Single-angle Hough line accumulator. Each vote item (action 0) whose pixel value exceeds
// vote_threshold computes rho = row*cos_coef + col*sin_coef + rho_offset, scales it by
// inv_rho_step, rounds to the nearest bin and bumps that bin's counter, which saturates at
// its maximum. Read items (action 1, or 3) return one bin's count; action 2 also clears it.
// Every item gives exactly one result item. Items are processed one at a time by a small
// sequencer around a single histogram RAM: a vote passes through the accept step, the two
// coordinate products, the offset add, the scale by inv_rho_step, bin rounding with the
// RAM read issued, then the write-back as read data returns; a read passes through accept,
// address and RAM read, then write-back. The result sits in an output register, so the next
// item is accepted while a result is still waiting; the block only holds an item in its
// last step when that register is still full. After reset the histogram is cleared by a
// pass over the RAM, one bin per cycle, during which no item is accepted; configuration
// writes are taken at any time.
// Configuration registers sit on the APB port at byte addresses 0x00 (cos_coef), 0x04
// (sin_coef), 0x08 (rho_offset), 0x0c (inv_rho_step) and 0x10 (vote_threshold); write them
// only while no item is in flight.

`default_nettype none

module hough_single_angle_rho_histogram #(
  parameter int NUM_BINS   = 1024,
  parameter int COORD_BITS = 10,
  parameter int COUNT_BITS = 20
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [hsarh_pkg::PADDR_W-1:0]   paddr,
  input  logic [hsarh_pkg::PDATA_W-1:0]   pwdata,
  output logic [hsarh_pkg::PDATA_W-1:0]   prdata,
  output logic                            pready,
  // item channels
  hsarh_req_if.sink                       req,
  hsarh_rsp_if.source                     rsp
);

  localparam int BIN_BITS = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int RW       = hsarh_pkg::ROW_W;
  localparam int SW       = hsarh_pkg::SUM_W;
  localparam int BW       = hsarh_pkg::BINW_W;
  localparam int IW       = hsarh_pkg::IDX_W;
  localparam int CW       = hsarh_pkg::CNT_W;
  localparam int WIDE_W   = 32;

  localparam logic [RW-1:0]         COORD_MASK = RW'((64'd1 << COORD_BITS) - 64'd1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;
  localparam logic [BIN_BITS-1:0]   LAST_BIN   = BIN_BITS'(NUM_BINS - 1);
  localparam logic [BW-1:0]         BINS_B     = BW'(NUM_BINS);
  localparam logic [WIDE_W-1:0]     BINS_W     = WIDE_W'(NUM_BINS);

  hsarh_pkg::cfg_t   cfg;
  hsarh_pkg::state_t state, state_next;

  // configuration registers and APB decode
  hsarh_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // item captured at acceptance
  logic [hsarh_pkg::ACT_W-1:0] act_q;
  logic [RW-1:0]               row_q;
  logic [RW-1:0]               col_q;
  logic [hsarh_pkg::SEL_W-1:0] sel_q;
  logic                        below_q;

  // rho datapath
  logic signed [hsarh_pkg::PROD_W-1:0]   prod_r;
  logic signed [hsarh_pkg::PROD_W-1:0]   prod_c;
  logic signed [SW-1:0]                  sum_q;
  logic signed [hsarh_pkg::SCALED_W-1:0] scaled;
  logic signed [hsarh_pkg::SCALED_W-1:0] rounded;
  logic [BW-1:0]                         bin_wide;
  logic                                  is_vote;
  logic                                  oor_next;
  logic [BIN_BITS-1:0]                   addr_next;

  // bin held for the read-modify-write step
  logic [BIN_BITS-1:0] addr_q;
  logic                oor_q;

  // histogram memory
  logic [COUNT_BITS-1:0] hist_mem [NUM_BINS];
  logic [COUNT_BITS-1:0] rd_data;
  logic                  mem_we;
  logic                  mem_re;
  logic [BIN_BITS-1:0]   mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;
  logic [BIN_BITS-1:0]   clr_addr;

  // result handling
  logic [COUNT_BITS-1:0] incr;
  logic                  at_max;
  logic                  upd;
  logic [COUNT_BITS-1:0] upd_data;
  logic                  out_free;
  logic                  res_load;
  logic                  out_valid;
  hsarh_pkg::res_t       res;
  hsarh_pkg::res_t       out_res;

  // rounding to the nearest bin: add half a bin in Q30, keep the integer part
  assign is_vote  = (act_q == hsarh_pkg::ACT_VOTE);
  assign rounded  = scaled + hsarh_pkg::ROUND_HALF;
  assign bin_wide = rounded[hsarh_pkg::SCALED_W-2:hsarh_pkg::FRAC_W];
  assign oor_next = is_vote ? (rounded[hsarh_pkg::SCALED_W-1] || (bin_wide >= BINS_B))
                            : (WIDE_W'(sel_q) >= BINS_W);
  assign addr_next = is_vote ? BIN_BITS'(bin_wide) : BIN_BITS'(sel_q);

  assign incr     = rd_data + COUNT_BITS'(1);
  assign at_max   = (rd_data == COUNT_MAX);
  assign out_free = !out_valid || rsp.ready;

  // sequencer
  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    mem_re     = 1'b0;
    res_load   = 1'b0;
    case (state)
      hsarh_pkg::ST_CLEAR: begin
        if (clr_addr == LAST_BIN) state_next = hsarh_pkg::ST_IDLE;
      end
      hsarh_pkg::ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          state_next = (req.action == hsarh_pkg::ACT_VOTE) ? hsarh_pkg::ST_MUL
                                                           : hsarh_pkg::ST_ADDR;
        end
      end
      hsarh_pkg::ST_MUL:   state_next = hsarh_pkg::ST_SUM;
      hsarh_pkg::ST_SUM:   state_next = hsarh_pkg::ST_SCALE;
      hsarh_pkg::ST_SCALE: state_next = hsarh_pkg::ST_ADDR;
      hsarh_pkg::ST_ADDR: begin
        mem_re     = !oor_next;
        state_next = hsarh_pkg::ST_DONE;
      end
      hsarh_pkg::ST_DONE: begin
        if (out_free) begin
          res_load   = 1'b1;
          state_next = hsarh_pkg::ST_IDLE;
        end
      end
      default: state_next = hsarh_pkg::ST_IDLE;
    endcase
  end

  // result of the item in its last step, and the counter update it makes
  always_comb begin
    res      = '0;
    upd      = 1'b0;
    upd_data = '0;
    if (is_vote) begin
      res.kind = hsarh_pkg::KIND_VOTE;
      if (below_q) begin
        // pixel too dark: all-zero answer, nothing counted
      end else if (oor_q) begin
        res.out_of_range = 1'b1;
      end else if (at_max) begin
        res.bin_index = IW'(addr_q);
        res.bin_count = CW'(rd_data);
        res.saturated = 1'b1;
      end else begin
        res.bin_index = IW'(addr_q);
        res.bin_count = CW'(incr);
        res.voted     = 1'b1;
        res.saturated = (incr == COUNT_MAX);
        upd           = 1'b1;
        upd_data      = incr;
      end
    end else begin
      res.kind      = hsarh_pkg::KIND_READ;
      res.bin_index = IW'(sel_q);
      if (oor_q) begin
        res.out_of_range = 1'b1;
      end else begin
        res.bin_count = CW'(rd_data);
        res.saturated = at_max;
        upd           = (act_q == hsarh_pkg::ACT_READ_CLEAR);
      end
    end
  end

  // write port: clearing pass after reset, else write-back of the item's update
  always_comb begin
    if (state == hsarh_pkg::ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else begin
      mem_we    = res_load && upd;
      mem_waddr = addr_q;
      mem_wdata = upd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) hist_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data <= hist_mem[addr_next];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= hsarh_pkg::ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == hsarh_pkg::ST_CLEAR) clr_addr <= clr_addr + BIN_BITS'(1);
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers, one step per state
  always_ff @(posedge clk) begin
    case (state)
      hsarh_pkg::ST_IDLE: begin
        if (req.valid) begin
          act_q   <= req.action;
          row_q   <= req.row & COORD_MASK;
          col_q   <= req.col & COORD_MASK;
          sel_q   <= req.bin_select;
          below_q <= (req.pixel_value <= cfg.vote_threshold);
        end
      end
      hsarh_pkg::ST_MUL: begin
        prod_r <= $signed({1'b0, row_q}) * cfg.cos_coef;
        prod_c <= $signed({1'b0, col_q}) * cfg.sin_coef;
      end
      hsarh_pkg::ST_SUM: begin
        sum_q <= SW'(prod_r) + SW'(prod_c) + $signed(SW'(cfg.rho_offset));
      end
      hsarh_pkg::ST_SCALE: begin
        scaled <= sum_q * $signed({1'b0, cfg.inv_rho_step});
      end
      hsarh_pkg::ST_ADDR: begin
        addr_q <= addr_next;
        oor_q  <= oor_next;
      end
      default: begin
      end
    endcase
    if (res_load) out_res <= res;
  end

  assign rsp.valid        = out_valid;
  assign rsp.kind         = out_res.kind;
  assign rsp.bin_index    = out_res.bin_index;
  assign rsp.bin_count    = out_res.bin_count;
  assign rsp.voted        = out_res.voted;
  assign rsp.out_of_range = out_res.out_of_range;
  assign rsp.saturated    = out_res.saturated;

endmodule

`default_nettype wire

// File: design/hsarh_chk.sv
`default_nettype none

module hsarh_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic                          kind,
  input logic                          voted,
  input logic                          out_of_range,
  input logic                          saturated,
  input logic [hsarh_pkg::CNT_W-1:0]   bin_count
);

  // reset empties the output and starts the clearing pass
  a_reset_quiet: assert property (@(posedge clk) rst |=> !rsp_valid && !req_ready)
    else $error("output or input open right after reset");

  // one item in flight: an accepted item closes the input
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("input still ready after an item was taken");

  // an out-of-range answer carries no count
  a_oor_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && out_of_range |-> bin_count == '0 && !voted && !saturated)
    else $error("out-of-range result with count or flags");

  // reads never vote
  a_read_no_vote: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && kind |-> !voted)
    else $error("read result marked as voted");

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(bin_count) && $stable(kind))
    else $error("result changed while stalled");

endmodule

bind hough_single_angle_rho_histogram hsarh_chk u_hsarh_chk (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .kind         (rsp.kind),
  .voted        (rsp.voted),
  .out_of_range (rsp.out_of_range),
  .saturated    (rsp.saturated),
  .bin_count    (rsp.bin_count)
);

`default_nettype wire

// File: tb/hough_single_angle_rho_histogram_tb.sv
`timescale 1ns / 1ps

module hough_single_angle_rho_histogram_tb;

  localparam int NUM_BINS    = 1024;
  localparam int CYCLE_LIMIT = 400000;
  localparam int REPORT_MAX  = 10;

  // the action code the package leaves unnamed
  localparam logic [hsarh_pkg::ACT_W-1:0] ACT_SPARE = 2'd3;
  localparam logic [hsarh_pkg::CNT_W-1:0] COUNT_MAX = {hsarh_pkg::CNT_W{1'b1}};

  typedef struct packed {
    logic [hsarh_pkg::ACT_W-1:0] action;
    logic [hsarh_pkg::ROW_W-1:0] row;
    logic [hsarh_pkg::ROW_W-1:0] col;
    logic [hsarh_pkg::PIX_W-1:0] pixel_value;
    logic [hsarh_pkg::SEL_W-1:0] bin_select;
  } hist_req_t;

  logic                          clk;
  logic                          rst;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [hsarh_pkg::PADDR_W-1:0] paddr;
  logic [hsarh_pkg::PDATA_W-1:0] pwdata;
  logic [hsarh_pkg::PDATA_W-1:0] prdata;
  logic                          pready;

  hsarh_req_if req_ch ();
  hsarh_rsp_if rsp_ch ();

  hough_single_angle_rho_histogram dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req     (req_ch),
    .rsp     (rsp_ch)
  );

  // shadow of the block: register file and the rho histogram itself
  hsarh_pkg::cfg_t             hist_cfg;
  logic [hsarh_pkg::CNT_W-1:0] bin_tally [NUM_BINS];

  // items waiting to be driven, and results owed by the block in order
  hist_req_t       hist_requests [$];
  hsarh_pkg::res_t bin_reports_due [$];
  int              hit_bins [$];

  hist_req_t on_bus;
  int        queued_total;
  int        accepted_total;
  int        fault_count;
  int        cycle_count;
  int        burst_left;
  int        gap_left;
  int        hold_left;
  int        long_holds;
  int        window_left;
  int        stall_pct;
  logic [hsarh_pkg::ROW_W-1:0] last_row;
  logic [hsarh_pkg::ROW_W-1:0] last_col;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // rounded bin for a pixel under the current angle, -1 when rho lands below zero
  function automatic longint rho_bin(input logic [hsarh_pkg::ROW_W-1:0] r,
                                     input logic [hsarh_pkg::ROW_W-1:0] c);
    longint s;
    longint p;
    s = longint'(r) * longint'(hist_cfg.cos_coef) + longint'(c) * longint'(hist_cfg.sin_coef)
        + longint'(hist_cfg.rho_offset);
    p = s * longint'(hist_cfg.inv_rho_step) + (longint'(1) << (hsarh_pkg::FRAC_W - 1));
    if (p < 0) return -1;
    return p >>> hsarh_pkg::FRAC_W;
  endfunction

  // applies one item to the shadow histogram and returns the result it must produce
  function automatic hsarh_pkg::res_t tally_item(input hist_req_t it);
    hsarh_pkg::res_t             o;
    longint                      b;
    logic [hsarh_pkg::CNT_W-1:0] c;
    o = '0;
    if (it.action == hsarh_pkg::ACT_VOTE) begin
      o.kind = hsarh_pkg::KIND_VOTE;
      if (it.pixel_value > hist_cfg.vote_threshold) begin
        b = rho_bin(it.row, it.col);
        if (b < 0 || b >= NUM_BINS) begin
          o.out_of_range = 1'b1;
        end else begin
          c = bin_tally[b];
          o.bin_index = hsarh_pkg::IDX_W'(b);
          if (c == COUNT_MAX) begin
            o.bin_count = c;
            o.saturated = 1'b1;
          end else begin
            c = c + 1'b1;
            bin_tally[b] = c;
            o.bin_count = c;
            o.voted = 1'b1;
            o.saturated = (c == COUNT_MAX);
          end
        end
      end
    end else begin
      // read, read-and-clear, and the spare code which reads without clearing
      o.kind = hsarh_pkg::KIND_READ;
      o.bin_index = it.bin_select;
      if (int'(it.bin_select) >= NUM_BINS) begin
        o.out_of_range = 1'b1;
      end else begin
        c = bin_tally[it.bin_select];
        if (it.action == hsarh_pkg::ACT_READ_CLEAR) bin_tally[it.bin_select] = '0;
        o.bin_count = c;
        o.saturated = (c == COUNT_MAX);
      end
    end
    return o;
  endfunction

  task automatic log_fault(input string what, input hsarh_pkg::res_t want,
                           input hsarh_pkg::res_t got);
    fault_count++;
    if (fault_count <= REPORT_MAX)
      $display({"%s: expected kind=%0d bin=%0d count=%0d voted=%0d oor=%0d sat=%0d",
                " | got kind=%0d bin=%0d count=%0d voted=%0d oor=%0d sat=%0d"},
               what, want.kind, want.bin_index, want.bin_count, want.voted,
               want.out_of_range, want.saturated, got.kind, got.bin_index, got.bin_count,
               got.voted, got.out_of_range, got.saturated);
  endtask

  // apb write: setup cycle, access cycle, register taken at the edge with pready high
  task automatic apb_write(input logic [hsarh_pkg::REGIX_W-1:0] ix,
                           input logic [hsarh_pkg::PDATA_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {ix, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (ix)
      hsarh_pkg::REG_COS_COEF:
        hist_cfg.cos_coef = val[hsarh_pkg::COEF_W-1:0];
      hsarh_pkg::REG_SIN_COEF:
        hist_cfg.sin_coef = val[hsarh_pkg::COEF_W-1:0];
      hsarh_pkg::REG_RHO_OFFSET:
        hist_cfg.rho_offset = val[hsarh_pkg::OFFS_W-1:0];
      hsarh_pkg::REG_INV_RHO_STEP:
        hist_cfg.inv_rho_step = val[hsarh_pkg::STEP_W-1:0];
      hsarh_pkg::REG_VOTE_THRESHOLD:
        hist_cfg.vote_threshold = val[hsarh_pkg::THR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_angle_cfg(input logic signed [hsarh_pkg::COEF_W-1:0] cs,
                               input logic signed [hsarh_pkg::COEF_W-1:0] sn,
                               input logic [hsarh_pkg::OFFS_W-1:0] offs,
                               input logic [hsarh_pkg::STEP_W-1:0] step,
                               input logic [hsarh_pkg::THR_W-1:0] thr);
    apb_write(hsarh_pkg::REG_COS_COEF, hsarh_pkg::PDATA_W'($unsigned(cs)));
    apb_write(hsarh_pkg::REG_SIN_COEF, hsarh_pkg::PDATA_W'($unsigned(sn)));
    apb_write(hsarh_pkg::REG_RHO_OFFSET, hsarh_pkg::PDATA_W'(offs));
    apb_write(hsarh_pkg::REG_INV_RHO_STEP, hsarh_pkg::PDATA_W'(step));
    apb_write(hsarh_pkg::REG_VOTE_THRESHOLD, hsarh_pkg::PDATA_W'(thr));
  endtask

  // every item yields one result, so once all results are back the block is idle
  task automatic wait_all_reported();
    while (accepted_total != queued_total || bin_reports_due.size() != 0) @(posedge clk);
  endtask

  task automatic queue_item(input logic [hsarh_pkg::ACT_W-1:0] act, input int r, input int c,
                            input int pix, input int sel);
    hist_req_t it;
    it.action      = act;
    it.row         = hsarh_pkg::ROW_W'(r);
    it.col         = hsarh_pkg::ROW_W'(c);
    it.pixel_value = hsarh_pkg::PIX_W'(pix);
    it.bin_select  = hsarh_pkg::SEL_W'(sel);
    hist_requests.push_back(it);
    queued_total++;
  endtask

  // random traffic: mostly votes clustered so bins repeat, reads aimed at bins just hit
  task automatic queue_random_items(input int n);
    hist_req_t                   it;
    int                          pick;
    longint                      b;
    logic [hsarh_pkg::ROW_W-1:0] hot_row;
    logic [hsarh_pkg::ROW_W-1:0] hot_col;
    hot_row = $urandom;
    hot_col = $urandom;
    hit_bins.delete();
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      it.row         = $urandom;
      it.col         = $urandom;
      it.pixel_value = $urandom;
      it.bin_select  = $urandom;
      if (pick < 60) begin
        it.action = hsarh_pkg::ACT_VOTE;
        case ($urandom_range(0, 2))
          1: begin
            it.row = hot_row + hsarh_pkg::ROW_W'($urandom_range(0, 7));
            it.col = hot_col + hsarh_pkg::ROW_W'($urandom_range(0, 7));
          end
          2: begin
            // same pixel again right behind the last vote: back-to-back bin update
            it.row = last_row;
            it.col = last_col;
          end
          default: ;
        endcase
        // threshold edge: equal does not vote, one above does
        case ($urandom_range(0, 7))
          0: it.pixel_value = hist_cfg.vote_threshold;
          1: it.pixel_value = hist_cfg.vote_threshold + 1'b1;
          default: ;
        endcase
        last_row = it.row;
        last_col = it.col;
        b = rho_bin(it.row, it.col);
        if (it.pixel_value > hist_cfg.vote_threshold && b >= 0 && b < NUM_BINS) begin
          hit_bins.push_back(int'(b));
          if (hit_bins.size() > 16) void'(hit_bins.pop_front());
        end
      end else begin
        it.action = (pick < 75) ? hsarh_pkg::ACT_READ :
                    (pick < 92) ? hsarh_pkg::ACT_READ_CLEAR : ACT_SPARE;
        if (hit_bins.size() != 0 && $urandom_range(0, 3) != 0)
          it.bin_select = hsarh_pkg::SEL_W'(hit_bins[$urandom_range(0, hit_bins.size() - 1)]);
      end
      hist_requests.push_back(it);
      queued_total++;
    end
  endtask

  // stimulus and run control
  initial begin
    clk = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_ch.valid = 1'b0;
    req_ch.action = hsarh_pkg::ACT_VOTE;
    req_ch.row = '0;
    req_ch.col = '0;
    req_ch.pixel_value = '0;
    req_ch.bin_select = '0;
    rsp_ch.ready = 1'b0;
    // register reset values: cos 0, sin 1.0, no offset, unit step, threshold 0
    hist_cfg = '{cos_coef: 16'sd0, sin_coef: 16'sd16384, rho_offset: '0,
                 inv_rho_step: 20'd65536, vote_threshold: 8'd0};
    foreach (bin_tally[i]) bin_tally[i] = '0;
    last_row = '0;
    last_col = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed, reset angle: bin equals the column
    queue_item(hsarh_pkg::ACT_VOTE, 0, 0, 255, 0);
    queue_item(hsarh_pkg::ACT_VOTE, 1023, 0, 0, 0);         // not above threshold
    queue_item(hsarh_pkg::ACT_VOTE, 1023, 1023, 1, 0);      // top bin
    queue_item(hsarh_pkg::ACT_VOTE, 5, 5, 128, 0);
    queue_item(hsarh_pkg::ACT_VOTE, 700, 5, 1, 0);          // same bin back to back
    queue_item(hsarh_pkg::ACT_VOTE, 0, 5, 255, 0);
    queue_item(hsarh_pkg::ACT_READ, 0, 0, 0, 5);
    queue_item(hsarh_pkg::ACT_READ_CLEAR, 0, 0, 0, 5);
    queue_item(hsarh_pkg::ACT_READ, 0, 0, 0, 5);            // cleared bin reads zero
    queue_item(ACT_SPARE, 0, 0, 0, 1023);                   // spare code reads, no clear
    queue_item(hsarh_pkg::ACT_READ_CLEAR, 0, 0, 0, 1023);
    queue_item(hsarh_pkg::ACT_READ, 0, 0, 0, 1023);
    queue_item(hsarh_pkg::ACT_READ, 0, 0, 0, 0);
    queue_item(hsarh_pkg::ACT_VOTE, 0, 6, 255, 0);
    queue_item(hsarh_pkg::ACT_READ, 0, 0, 0, 6);            // read right behind a vote
    wait_all_reported();

    // rho = col - row: negative rho falls out of range
    set_angle_cfg(-16'sd16384, 16'sd16384, '0, 20'd65536, 8'd200);
    queue_item(hsarh_pkg::ACT_VOTE, 1, 0, 201, 0);
    queue_item(hsarh_pkg::ACT_VOTE, 0, 0, 200, 0);
    queue_item(hsarh_pkg::ACT_VOTE, 0, 1023, 255, 0);
    wait_all_reported();

    // rho = row + col: beyond the last bin
    set_angle_cfg(16'sd16384, 16'sd16384, '0, 20'd65536, 8'd0);
    queue_item(hsarh_pkg::ACT_VOTE, 1023, 1023, 255, 0);
    queue_item(hsarh_pkg::ACT_VOTE, 512, 512, 255, 0);
    wait_all_reported();

    // inverse step of one half: rounding of exact halves goes up
    set_angle_cfg(16'sd16384, 16'sd0, '0, 20'd32768, 8'd0);
    queue_item(hsarh_pkg::ACT_VOTE, 1, 0, 9, 0);
    queue_item(hsarh_pkg::ACT_VOTE, 3, 0, 9, 0);
    queue_item(hsarh_pkg::ACT_VOTE, 2, 0, 9, 0);
    wait_all_reported();

    // a saturated bin needs 2^20 - 1 votes on it, far past the run length, so that
    // branch of the predictor is carried but not reached

    set_angle_cfg(16'sd16384, 16'sd16384, '0, 20'd65536, 8'd0);
    queue_random_items(220);
    wait_all_reported();

    set_angle_cfg(-16'sd16384, 16'sd16384, '0, 20'd65536, 8'd100);
    queue_random_items(220);
    wait_all_reported();

    // both coefficients at -1 with a full diagonal offset keeps every bin in range
    set_angle_cfg(-16'sd16384, -16'sd16384, hsarh_pkg::OFFS_W'(2046 << 14), 20'd32768, 8'd0);
    queue_random_items(240);
    wait_all_reported();

    // zero step: every vote lands in bin 0
    set_angle_cfg(16'sd11585, 16'sd11585, '0, '0, 8'd0);
    queue_random_items(200);
    wait_all_reported();

    // offset and step at their maxima; threshold 255 lets nothing vote
    set_angle_cfg(16'sd0, -16'sd16384, {hsarh_pkg::OFFS_W{1'b1}},
                  {hsarh_pkg::STEP_W{1'b1}}, 8'd255);
    queue_random_items(60);
    wait_all_reported();

    for (int ph = 0; ph < 3; ph++) begin
      set_angle_cfg(hsarh_pkg::COEF_W'($urandom_range(0, 32768) - 16384),
                    hsarh_pkg::COEF_W'($urandom_range(0, 32768) - 16384),
                    hsarh_pkg::OFFS_W'($urandom_range(0, (1 << hsarh_pkg::OFFS_W) - 1)),
                    hsarh_pkg::STEP_W'($urandom_range(0, 98304)),
                    hsarh_pkg::THR_W'($urandom_range(0, 200)));
      queue_random_items(170);
      wait_all_reported();
    end

    repeat (20) @(posedge clk);
    if (fault_count == 0 && bin_reports_due.size() == 0) begin
      $display("hough_single_angle_rho_histogram_tb: clean");
    end else begin
      $display("hough_single_angle_rho_histogram_tb: errors");
    end
    $finish;
  end

  // item driver: bursts of random length with random gaps, payload held while stalled
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      // an item taken at this edge is applied to the shadow histogram in order
      if (req_ch.valid && req_ch.ready) begin
        bin_reports_due.push_back(tally_item(on_bus));
        accepted_total++;
      end
      if (req_ch.valid && !req_ch.ready) begin
        // stalled: keep the item on the bus untouched
      end else if (gap_left > 0) begin
        gap_left--;
        req_ch.valid <= 1'b0;
      end else if (hist_requests.size() != 0) begin
        on_bus = hist_requests.pop_front();
        req_ch.valid       <= 1'b1;
        req_ch.action      <= on_bus.action;
        req_ch.row         <= on_bus.row;
        req_ch.col         <= on_bus.col;
        req_ch.pixel_value <= on_bus.pixel_value;
        req_ch.bin_select  <= on_bus.bin_select;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          // some bursts run straight into the next with no gap at all
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
        end else begin
          burst_left--;
        end
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // result receiver: stall density changes every window; twice a long hold-off so the
  // output register stays full and the block backs up into its input
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      hold_left = 0;
      long_holds = 0;
      window_left = 0;
      stall_pct = 0;
    end else if (hold_left > 0) begin
      hold_left--;
      rsp_ch.ready <= 1'b0;
    end else if (long_holds < 2 && accepted_total >= 300 + 700 * long_holds) begin
      long_holds++;
      hold_left = 400;
      rsp_ch.ready <= 1'b0;
    end else begin
      if (window_left == 0) begin
        window_left = 64;
        case ($urandom_range(0, 4))
          0, 1: stall_pct = 0;
          2: stall_pct = 25;
          3: stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      window_left--;
      rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // result monitor: each accepted result against the oldest owed one
  always @(posedge clk) begin
    hsarh_pkg::res_t got;
    hsarh_pkg::res_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got.kind         = rsp_ch.kind;
      got.bin_index    = rsp_ch.bin_index;
      got.bin_count    = rsp_ch.bin_count;
      got.voted        = rsp_ch.voted;
      got.out_of_range = rsp_ch.out_of_range;
      got.saturated    = rsp_ch.saturated;
      if (bin_reports_due.size() == 0) begin
        log_fault("result with nothing owed", '0, got);
      end else begin
        want = bin_reports_due.pop_front();
        if (got.kind !== want.kind || got.bin_index !== want.bin_index ||
            got.bin_count !== want.bin_count || got.voted !== want.voted ||
            got.out_of_range !== want.out_of_range || got.saturated !== want.saturated)
          log_fault("result mismatch", want, got);
      end
    end
  end

  // run-length guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("hough_single_angle_rho_histogram_tb: errors");
      $finish;
    end
  end

endmodule

// File: files.f
design/hsarh_pkg.sv
design/hsarh_req_if.sv
design/hsarh_rsp_if.sv
design/hsarh_regs.sv
design/hough_single_angle_rho_histogram.sv
design/hsarh_chk.sv
tb/hough_single_angle_rho_histogram_tb.sv
